// ----- rtl/xypd_pkg.sv -----
// ----------------------------------------------------------------------------
// xypd_pkg
// Shared types and opcode constants of the point display I/O controller.
// ----------------------------------------------------------------------------
`default_nettype none

package xypd_pkg;

	// Model A opcodes, device code 05
	localparam logic [11:0] OP_A_CLR_ALL  = 12'o6050;
	localparam logic [11:0] OP_A_CLR_DONE = 12'o6051;
	localparam logic [11:0] OP_A_SKIP     = 12'o6052;
	localparam logic [11:0] OP_A_LOAD_X   = 12'o6053;
	localparam logic [11:0] OP_A_LOAD_Y   = 12'o6054;
	localparam logic [11:0] OP_A_INTENS   = 12'o6055;
	localparam logic [11:0] OP_A_LOAD_EN  = 12'o6056;
	localparam logic [11:0] OP_A_READ_ST  = 12'o6057;

	// Model B device codes (opcode bits 11..3)
	localparam logic [8:0] DEV_B_X      = 9'o605;
	localparam logic [8:0] DEV_B_Y      = 9'o606;
	localparam logic [8:0] DEV_B_BRIGHT = 9'o607;

	// Flags register layout
	localparam int FL_W        = 7;
	localparam int FL_EN_W     = 6;
	localparam int FL_DONE_BIT = 6;
	localparam int FL_IE_BIT   = 0;
	localparam int FL_CO_BIT   = 2;

	// Shade codes
	localparam logic [2:0] SHADE_GREEN = 3'd4;
	localparam logic [2:0] SHADE_RED   = 3'd5;

	localparam logic [1:0] BRIGHT_RESET = 2'd3;

	localparam logic CMD_EXEC  = 1'b0;
	localparam logic CMD_ERASE = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [11:0] opcode;
		logic [11:0] acc_in;
		logic        link_in;
	} item_t;

	typedef struct packed {
		logic [11:0] acc_out;
		logic        link_out;
		logic        skip;
		logic        unsupported;
		logic        point_valid;
		logic [9:0]  point_x;
		logic [9:0]  point_y;
		logic [2:0]  point_shade;
		logic        irq;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/xypd_core.sv -----
// ----------------------------------------------------------------------------
// xypd_core
// Controller state and instruction decode: computes the result of one item
// and commits the state update when the item is stepped.
// ----------------------------------------------------------------------------
`default_nettype none

module xypd_core #(
	parameter int COORD_RANGE = 1024
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   model_b,
	input  wire                   step_en,
	input  xypd_pkg::item_t       item,
	output xypd_pkg::result_t     result
);

	// coordinate range is a power of two: wrap is a mask
	localparam int CW   = $clog2(COORD_RANGE);
	localparam int XW   = (CW > 10) ? CW : 10;
	localparam logic [CW-1:0] HALF = CW'(COORD_RANGE / 2);

	logic [xypd_pkg::FL_W-1:0] flags_q, flags_d;
	logic [CW-1:0]             x_buf_q, x_buf_d;
	logic [CW-1:0]             y_buf_q, y_buf_d;
	logic [1:0]                bright_q, bright_d;

	logic [11:0]   acc;
	logic          skip;
	logic          unsup;
	logic          pv;
	logic [2:0]    shade;
	logic [8:0]    dev;
	logic [2:0]    fn;
	logic [CW-1:0] acc_wrap;
	logic [CW-1:0] buf_tmp;
	logic [XW-1:0] x_ext;
	logic [XW-1:0] y_ext;

	assign dev      = item.opcode[11:3];
	assign fn       = item.opcode[2:0];
	assign acc_wrap = CW'(item.acc_in);

	always_comb begin
		flags_d  = flags_q;
		x_buf_d  = x_buf_q;
		y_buf_d  = y_buf_q;
		bright_d = bright_q;
		acc      = item.acc_in;
		skip     = 1'b0;
		unsup    = 1'b0;
		pv       = 1'b0;
		shade    = 3'd0;
		buf_tmp  = '0;
		if (item.cmd == xypd_pkg::CMD_ERASE) begin
			flags_d[xypd_pkg::FL_DONE_BIT] = 1'b1;
		end else if (!model_b) begin
			case (item.opcode)
				xypd_pkg::OP_A_CLR_ALL: begin
					flags_d = '0;
				end
				xypd_pkg::OP_A_CLR_DONE: begin
					flags_d[xypd_pkg::FL_DONE_BIT] = 1'b0;
				end
				xypd_pkg::OP_A_SKIP: begin
					skip = flags_q[xypd_pkg::FL_DONE_BIT];
				end
				xypd_pkg::OP_A_LOAD_X: begin
					x_buf_d = acc_wrap + HALF;
					flags_d[xypd_pkg::FL_DONE_BIT] = 1'b1;
				end
				xypd_pkg::OP_A_LOAD_Y: begin
					y_buf_d = acc_wrap + HALF;
					flags_d[xypd_pkg::FL_DONE_BIT] = 1'b1;
				end
				xypd_pkg::OP_A_INTENS: begin
					pv    = 1'b1;
					shade = flags_q[xypd_pkg::FL_CO_BIT] ? xypd_pkg::SHADE_RED
						: xypd_pkg::SHADE_GREEN;
				end
				xypd_pkg::OP_A_LOAD_EN: begin
					flags_d = {flags_q[xypd_pkg::FL_DONE_BIT],
						item.acc_in[xypd_pkg::FL_EN_W-1:0]};
					acc = '0;
				end
				xypd_pkg::OP_A_READ_ST: begin
					// done at bit 11, enables at 5..0
					acc = {flags_q[xypd_pkg::FL_DONE_BIT], 5'b0,
						flags_q[xypd_pkg::FL_EN_W-1:0]};
				end
				default: begin
					unsup = 1'b1;
				end
			endcase
		end else begin
			if (dev inside {xypd_pkg::DEV_B_X, xypd_pkg::DEV_B_Y} && fn != 3'd0) begin
				// clear, then OR, then intensify
				buf_tmp = (dev == xypd_pkg::DEV_B_Y) ? y_buf_q : x_buf_q;
				if (fn[0]) begin
					buf_tmp = '0;
				end
				if (fn[1]) begin
					buf_tmp = buf_tmp | acc_wrap;
				end
				if (fn[2]) begin
					pv    = 1'b1;
					shade = {1'b0, bright_q};
				end
				if (dev == xypd_pkg::DEV_B_Y) begin
					y_buf_d = buf_tmp;
				end else begin
					x_buf_d = buf_tmp;
				end
			end else if (dev == xypd_pkg::DEV_B_BRIGHT && fn[2]) begin
				bright_d = fn[1:0];
			end else begin
				unsup = 1'b1;
			end
		end
	end

	assign x_ext = XW'(x_buf_d);
	assign y_ext = XW'(y_buf_d);

	always_comb begin
		result.acc_out     = acc;
		result.link_out    = item.link_in;
		result.skip        = skip;
		result.unsupported = unsup;
		result.point_valid = pv;
		result.point_x     = pv ? x_ext[9:0] : 10'd0;
		result.point_y     = pv ? y_ext[9:0] : 10'd0;
		result.point_shade = pv ? shade : 3'd0;
		result.irq         = flags_d[xypd_pkg::FL_DONE_BIT] & flags_d[xypd_pkg::FL_IE_BIT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= '0;
			x_buf_q  <= '0;
			y_buf_q  <= '0;
			bright_q <= xypd_pkg::BRIGHT_RESET;
		end else if (step_en) begin
			flags_q  <= flags_d;
			x_buf_q  <= x_buf_d;
			y_buf_q  <= y_buf_d;
			bright_q <= bright_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/xy_point_display_io_controller.sv -----
// ----------------------------------------------------------------------------
// xy_point_display_io_controller
// Register interface of a point-plotting display controller, models A and B.
// ----------------------------------------------------------------------------
// Each item is either an I/O instruction (opcode, accumulator, link) or an
// erase-finished event from the host, and gives exactly one result item:
// returned accumulator and link, skip, unsupported flag, an optional point
// (x, y, shade) and the interrupt request. device_model picks the opcode set
// (0 = model A, 1 = model B) and must only be written while the block is
// idle; cfg_ready is always high. Throughput is one item per clock while
// out_stall is low: the item sits in an input register, the decode and
// state update (X/Y buffers, flags, brightness) happen in one short
// combinational step, and the result lands in an output register that
// drives out_valid. in_stall rises only while both registers are full and the sink
// holds out_stall. COORD_RANGE must be a power of two (64..4096); the
// buffers are log2(COORD_RANGE) bits wide and the point fields show their
// low 10 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module xy_point_display_io_controller #(
	parameter int COORD_RANGE = 1024
) (
	input  wire         clk,
	input  wire         arst_n,

	// configuration
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         device_model,

	// input item channel
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         cmd,
	input  wire  [11:0] opcode,
	input  wire  [11:0] acc_in,
	input  wire         link_in,

	// result item channel
	output logic        out_valid,
	input  wire         out_stall,
	output logic [11:0] acc_out,
	output logic        link_out,
	output logic        skip,
	output logic        unsupported,
	output logic        point_valid,
	output logic [9:0]  point_x,
	output logic [9:0]  point_y,
	output logic [2:0]  point_shade,
	output logic        irq
);

	logic               model_q;
	logic               valid_s1;
	xypd_pkg::item_t    item_s1;
	logic               valid_s2;
	xypd_pkg::result_t  res_s2;
	xypd_pkg::result_t  result;
	logic               advance;
	logic               in_take;

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			model_q <= device_model;
		end
	end

	// item moves from input reg to result reg when the result reg is free
	// or is being drained this cycle
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.cmd     <= cmd;
			item_s1.opcode  <= opcode;
			item_s1.acc_in  <= acc_in;
			item_s1.link_in <= link_in;
		end
	end

	// decode and state; state commits on advance
	xypd_core #(
		.COORD_RANGE (COORD_RANGE)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.model_b (model_q),
		.step_en (advance),
		.item    (item_s1),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign out_valid   = valid_s2;
	assign acc_out     = res_s2.acc_out;
	assign link_out    = res_s2.link_out;
	assign skip        = res_s2.skip;
	assign unsupported = res_s2.unsupported;
	assign point_valid = res_s2.point_valid;
	assign point_x     = res_s2.point_x;
	assign point_y     = res_s2.point_y;
	assign point_shade = res_s2.point_shade;
	assign irq         = res_s2.irq;

endmodule

`default_nettype wire

// ----- rtl/xypd_checker.sv -----
// ----------------------------------------------------------------------------
// xypd_checker
// Port-level checks of the point display I/O controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module xypd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_stall,
	input wire [11:0] acc_out,
	input wire        skip,
	input wire        unsupported,
	input wire        point_valid,
	input wire [9:0]  point_x,
	input wire [9:0]  point_y,
	input wire [2:0]  point_shade
);

	// a rejected opcode neither skips nor plots
	a_unsup_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported |-> !skip && !point_valid)
		else $error("unsupported item skipped or plotted");

	// skip and plot come from different opcodes
	a_skip_no_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && skip |-> !point_valid)
		else $error("skip and point in one item");

	// no point: coordinate and shade fields are zero
	a_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> point_x == 10'd0 && point_y == 10'd0
			&& point_shade == 3'd0)
		else $error("point fields not cleared");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(acc_out) && $stable(point_x))
		else $error("stalled result changed");

endmodule

bind xy_point_display_io_controller xypd_checker u_xypd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.acc_out     (acc_out),
	.skip        (skip),
	.unsupported (unsupported),
	.point_valid (point_valid),
	.point_x     (point_x),
	.point_y     (point_y),
	.point_shade (point_shade)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the point display I/O controller, models A and B.
// Drives instructions and erase events with random gaps and back-pressure.
// A cycle-free predictor works out each result. Results are compared field
// by field, in order, as they leave the block.
// ----------------------------------------------------------------------------

module tb_top;

	// device_model settings
	localparam logic MODEL_A = 1'b0;
	localparam logic MODEL_B = 1'b1;

	// model B function bits (opcode bits 2..0)
	localparam logic [2:0] FN_CLR = 3'b001;   // clear the buffer
	localparam logic [2:0] FN_OR  = 3'b010;   // OR in the accumulator
	localparam logic [2:0] FN_INT = 3'b100;   // intensify; selects level on dev 07
	localparam int FN_CLR_BIT = 0;
	localparam int FN_OR_BIT  = 1;
	localparam int FN_INT_BIT = 2;

	// model A centers coordinates by half the range (1024 / 2)
	localparam logic [9:0] HALF_RANGE = 10'd512;

	// idle draw styles for sender and receiver
	localparam int IDLE_NONE   = 0;
	localparam int IDLE_FULL   = 1;
	localparam int IDLE_SPARSE = 2;

	localparam int MAX_IDLE       = 18;
	localparam int LONG_HOLD      = 150;   // receiver hold-off in the pressure test
	localparam int QUIET_LIMIT    = 2000;  // cycles with no handshake at all
	localparam int RESULT_LATENCY = 2;     // pipeline depth: input and result registers
	localparam int PHASE_ITEMS    = 230;
	localparam int PRESSURE_ITEMS = 40;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        device_model;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [11:0] opcode;
	logic [11:0] acc_in;
	logic        link_in;
	logic        out_valid;
	logic        out_stall;
	logic [11:0] acc_out;
	logic        link_out;
	logic        skip;
	logic        unsupported;
	logic        point_valid;
	logic [9:0]  point_x;
	logic [9:0]  point_y;
	logic [2:0]  point_shade;
	logic        irq;

	xy_point_display_io_controller #(
		.COORD_RANGE(1024)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.device_model(device_model),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.opcode      (opcode),
		.acc_in      (acc_in),
		.link_in     (link_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.acc_out     (acc_out),
		.link_out    (link_out),
		.skip        (skip),
		.unsupported (unsupported),
		.point_valid (point_valid),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_shade (point_shade),
		.irq         (irq)
	);

	// Predicted controller state. Updated when an item or a config write is
	// accepted, so it always matches what the block has been given so far.
	logic       plot_model;
	logic [6:0] plot_flags;    // bit 6 done, bits 5..0 enables (IE at bit 0)
	logic [9:0] plot_x;
	logic [9:0] plot_y;
	logic [1:0] plot_bright;

	xypd_pkg::result_t pending_io_results[$];   // oldest first
	int unsigned err_count = 0;
	int unsigned quiet_cycles = 0;

	int src_idle_mode;
	int sink_idle_mode;
	int unsigned sink_hold;           // one-shot long hold for the receiver

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor: one instruction or erase event in, one result out.
	// ------------------------------------------------------------------------
	function automatic xypd_pkg::result_t predict_io_result(input xypd_pkg::item_t it);
		xypd_pkg::result_t r;
		logic [11:0] acc;
		logic [8:0]  dev;
		logic [2:0]  fn;
		logic [9:0]  coord;
		logic        pv;
		logic [2:0]  shade;
		r     = '0;
		acc   = it.acc_in;
		pv    = 1'b0;
		shade = '0;
		dev   = it.opcode[11:3];
		fn    = it.opcode[2:0];
		if (it.cmd == xypd_pkg::CMD_ERASE) begin
			// erase finished sets done whatever the model, nothing else moves
			plot_flags[xypd_pkg::FL_DONE_BIT] = 1'b1;
		end else if (plot_model == MODEL_A) begin
			case (it.opcode)
				xypd_pkg::OP_A_CLR_ALL:  plot_flags = '0;
				xypd_pkg::OP_A_CLR_DONE: plot_flags[xypd_pkg::FL_DONE_BIT] = 1'b0;
				xypd_pkg::OP_A_SKIP:     r.skip = plot_flags[xypd_pkg::FL_DONE_BIT];
				xypd_pkg::OP_A_LOAD_X: begin
					// wrap of acc + 512 in a 1024 range only needs the low bits
					plot_x = acc[9:0] + HALF_RANGE;
					plot_flags[xypd_pkg::FL_DONE_BIT] = 1'b1;
				end
				xypd_pkg::OP_A_LOAD_Y: begin
					plot_y = acc[9:0] + HALF_RANGE;
					plot_flags[xypd_pkg::FL_DONE_BIT] = 1'b1;
				end
				xypd_pkg::OP_A_INTENS: begin
					pv    = 1'b1;
					shade = plot_flags[xypd_pkg::FL_CO_BIT] ? xypd_pkg::SHADE_RED
						: xypd_pkg::SHADE_GREEN;
				end
				xypd_pkg::OP_A_LOAD_EN: begin
					plot_flags = {plot_flags[xypd_pkg::FL_DONE_BIT],
						acc[xypd_pkg::FL_EN_W-1:0]};
					acc = '0;
				end
				xypd_pkg::OP_A_READ_ST: begin
					acc = {plot_flags[xypd_pkg::FL_DONE_BIT], 5'b0,
						plot_flags[xypd_pkg::FL_EN_W-1:0]};
				end
				default: r.unsupported = 1'b1;
			endcase
		end else begin
			if (dev inside {xypd_pkg::DEV_B_X, xypd_pkg::DEV_B_Y} && fn != 3'b000) begin
				// clear, then OR, then intensify, all within one item
				coord = (dev == xypd_pkg::DEV_B_X) ? plot_x : plot_y;
				if (fn[FN_CLR_BIT])
					coord = '0;
				if (fn[FN_OR_BIT])
					coord = coord | acc[9:0];
				if (dev == xypd_pkg::DEV_B_X)
					plot_x = coord;
				else
					plot_y = coord;
				if (fn[FN_INT_BIT]) begin
					pv    = 1'b1;
					shade = {1'b0, plot_bright};
				end
			end else if (dev == xypd_pkg::DEV_B_BRIGHT && fn[FN_INT_BIT]) begin
				plot_bright = fn[1:0];
			end else begin
				r.unsupported = 1'b1;
			end
		end
		r.acc_out     = acc;
		r.link_out    = it.link_in;
		r.point_valid = pv;
		if (pv) begin
			r.point_x     = plot_x;
			r.point_y     = plot_y;
			r.point_shade = shade;
		end
		r.irq = plot_flags[xypd_pkg::FL_DONE_BIT] & plot_flags[xypd_pkg::FL_IE_BIT];
		return r;
	endfunction

	function automatic xypd_pkg::item_t io_instr(input logic [11:0] op,
			input logic [11:0] acc, input logic link);
		xypd_pkg::item_t it;
		it.cmd     = xypd_pkg::CMD_EXEC;
		it.opcode  = op;
		it.acc_in  = acc;
		it.link_in = link;
		return it;
	endfunction

	function automatic int idle_cycles(input int mode);
		case (mode)
			IDLE_FULL:   return $urandom_range(0, MAX_IDLE);
			IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_IDLE) : 0;
			default:     return 0;
		endcase
	endfunction

	// Mostly opcodes the current model decodes, with random accumulator; the
	// rest is erase events and raw opcode noise.
	function automatic xypd_pkg::item_t random_io_item();
		xypd_pkg::item_t it;
		int    pick;
		it.cmd     = xypd_pkg::CMD_EXEC;
		it.link_in = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 7))
			0:       it.acc_in = '0;
			1:       it.acc_in = '1;
			default: it.acc_in = 12'($urandom_range(0, 4095));
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			it.cmd    = xypd_pkg::CMD_ERASE;
			it.opcode = 12'($urandom_range(0, 4095));
		end else if (pick < 16) begin
			it.opcode = 12'($urandom_range(0, 4095));
		end else if (plot_model == MODEL_A) begin
			case ($urandom_range(0, 7))
				0:       it.opcode = xypd_pkg::OP_A_CLR_ALL;
				1:       it.opcode = xypd_pkg::OP_A_CLR_DONE;
				2:       it.opcode = xypd_pkg::OP_A_SKIP;
				3:       it.opcode = xypd_pkg::OP_A_LOAD_X;
				4:       it.opcode = xypd_pkg::OP_A_LOAD_Y;
				5:       it.opcode = xypd_pkg::OP_A_INTENS;
				6:       it.opcode = xypd_pkg::OP_A_LOAD_EN;
				default: it.opcode = xypd_pkg::OP_A_READ_ST;
			endcase
		end else begin
			case ($urandom_range(0, 2))
				0:       it.opcode[11:3] = xypd_pkg::DEV_B_X;
				1:       it.opcode[11:3] = xypd_pkg::DEV_B_Y;
				default: it.opcode[11:3] = xypd_pkg::DEV_B_BRIGHT;
			endcase
			it.opcode[2:0] = 3'($urandom_range(0, 7));
		end
		return it;
	endfunction

	// ------------------------------------------------------------------------
	// Sender: optional gap, then hold the item until in_stall is low at an
	// edge. Valid stays up across back-to-back items (no drop/raise in one step).
	// ------------------------------------------------------------------------
	task automatic push_io_item(input xypd_pkg::item_t it);
		int gap;
		gap = idle_cycles(src_idle_mode);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= it.cmd;
		opcode   <= it.opcode;
		acc_in   <= it.acc_in;
		link_in  <= it.link_in;
		do @(posedge clk); while (in_stall);
		pending_io_results.push_back(predict_io_result(it));
	endtask

	// every item gives a result, so empty queue plus pipeline depth means idle
	task automatic wait_until_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_io_results.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_device_model(input logic model);
		wait_until_idle();
		@(negedge clk);
		cfg_valid    <= 1'b1;
		device_model <= model;
		do @(posedge clk); while (!cfg_ready);
		plot_model = model;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Model A: every opcode, status round trip, skip both ways, both shades,
	// irq rise and fall, erase event, opcodes outside device 05.
	task automatic test_model_a_decode();
		write_device_model(MODEL_A);
		// status at reset is zero
		push_io_item(io_instr(xypd_pkg::OP_A_READ_ST, 12'hFFF, 1'b1));
		// done clear: no skip
		push_io_item(io_instr(xypd_pkg::OP_A_SKIP, 12'h000, 1'b0));
		// green at origin
		push_io_item(io_instr(xypd_pkg::OP_A_INTENS, 12'h123, 1'b1));
		push_io_item(io_instr(xypd_pkg::OP_A_LOAD_X, 12'h000, 1'b0));
		// wraps past the range
		push_io_item(io_instr(xypd_pkg::OP_A_LOAD_Y, 12'hFFF, 1'b1));
		push_io_item(io_instr(xypd_pkg::OP_A_SKIP, 12'hFFF, 1'b1));
		// all enables, irq up
		push_io_item(io_instr(xypd_pkg::OP_A_LOAD_EN, 12'hFFF, 1'b0));
		// colour bit set: red
		push_io_item(io_instr(xypd_pkg::OP_A_INTENS, 12'h000, 1'b0));
		push_io_item(io_instr(xypd_pkg::OP_A_READ_ST, 12'h000, 1'b0));
		// irq drops
		push_io_item(io_instr(xypd_pkg::OP_A_CLR_DONE, 12'hFFF, 1'b1));
		// done again
		push_io_item('{xypd_pkg::CMD_ERASE, 12'hFFF, 12'hFFF, 1'b1});
		push_io_item(io_instr(xypd_pkg::OP_A_CLR_ALL, 12'hFFF, 1'b0));
		push_io_item(io_instr(12'h000, 12'hFFF, 1'b1));
		push_io_item(io_instr(12'hFFF, 12'h000, 1'b0));
		// model B code
		push_io_item(io_instr({xypd_pkg::DEV_B_BRIGHT, FN_INT}, 12'h555, 1'b1));
	endtask

	// Model B: each function bit alone and combined, brightness levels 0 and 3
	// used, no-function and out-of-range codes, erase event.
	task automatic test_model_b_decode();
		write_device_model(MODEL_B);
		push_io_item(io_instr({xypd_pkg::DEV_B_X, FN_CLR}, 12'hFFF, 1'b1));
		push_io_item(io_instr({xypd_pkg::DEV_B_X, FN_OR}, 12'hFFF, 1'b0));
		// reset level 3
		push_io_item(io_instr({xypd_pkg::DEV_B_X, FN_INT}, 12'h000, 1'b1));
		push_io_item(io_instr({xypd_pkg::DEV_B_BRIGHT, FN_INT | 3'd0}, 12'hFFF, 1'b0));
		push_io_item(io_instr({xypd_pkg::DEV_B_Y, FN_CLR | FN_OR | FN_INT}, 12'h155, 1'b1));
		push_io_item(io_instr({xypd_pkg::DEV_B_X, FN_CLR | FN_OR}, 12'h000, 1'b0));
		push_io_item(io_instr({xypd_pkg::DEV_B_X, FN_CLR | FN_INT}, 12'h3FF, 1'b1));
		push_io_item(io_instr({xypd_pkg::DEV_B_Y, FN_OR | FN_INT}, 12'hAAA, 1'b0));
		push_io_item(io_instr({xypd_pkg::DEV_B_BRIGHT, FN_INT | 3'd3}, 12'h000, 1'b1));
		// no function bits
		push_io_item(io_instr({xypd_pkg::DEV_B_X, 3'b000}, 12'hFFF, 1'b1));
		// level bit clear
		push_io_item(io_instr({xypd_pkg::DEV_B_BRIGHT, 3'b011}, 12'h000, 1'b0));
		push_io_item(io_instr(12'hFFF, 12'hFFF, 1'b1));
		push_io_item('{xypd_pkg::CMD_ERASE, 12'h000, 12'h000, 1'b0});
	endtask

	// Random traffic in phases; the model alternates and keeps state across
	// switches. Each phase uses its own mix of sender and receiver idling.
	task automatic test_random_traffic();
		for (int phase = 0; phase < 6; phase++) begin
			write_device_model(phase[0] ? MODEL_B : MODEL_A);
			case (phase)
				0: begin src_idle_mode = IDLE_NONE;   sink_idle_mode = IDLE_NONE;   end
				1: begin src_idle_mode = IDLE_FULL;   sink_idle_mode = IDLE_FULL;   end
				2: begin src_idle_mode = IDLE_SPARSE; sink_idle_mode = IDLE_FULL;   end
				3: begin src_idle_mode = IDLE_FULL;   sink_idle_mode = IDLE_SPARSE; end
				4: begin src_idle_mode = IDLE_NONE;   sink_idle_mode = IDLE_FULL;   end
				default: begin src_idle_mode = IDLE_FULL; sink_idle_mode = IDLE_NONE; end
			endcase
			repeat (PHASE_ITEMS) push_io_item(random_io_item());
		end
	endtask

	// Receiver holds off for a long stretch while items keep coming back to
	// back, so the pipe fills and in_stall has to rise.
	task automatic test_backpressure();
		write_device_model($urandom_range(0, 1) ? MODEL_B : MODEL_A);
		src_idle_mode  = IDLE_NONE;
		sink_idle_mode = IDLE_SPARSE;
		sink_hold      = LONG_HOLD;
		repeat (PRESSURE_ITEMS) push_io_item(random_io_item());
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		device_model   = MODEL_A;
		in_valid       = 1'b0;
		cmd            = xypd_pkg::CMD_EXEC;
		opcode         = '0;
		acc_in         = '0;
		link_in        = 1'b0;
		src_idle_mode  = IDLE_SPARSE;
		sink_idle_mode = IDLE_SPARSE;
		sink_hold      = 0;
		plot_model     = MODEL_A;
		plot_flags     = '0;
		plot_x         = '0;
		plot_y         = '0;
		plot_bright    = xypd_pkg::BRIGHT_RESET;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_model_a_decode();
		test_model_b_decode();
		test_random_traffic();
		test_backpressure();

		wait_until_idle();
		repeat (10) @(posedge clk);
		if (err_count == 0 && pending_io_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver: per result draw a stall, drop it, wait for the handshake.
	// A pending long hold replaces one draw.
	// ------------------------------------------------------------------------
	initial begin : sink_side
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				n = sink_hold;
				sink_hold = 0;
			end else begin
				n = idle_cycles(sink_idle_mode);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// ------------------------------------------------------------------------
	// Result check: in order, field by field
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		xypd_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_io_results.size() == 0) begin
				$display("%0t: result item with nothing expected, acc_out %03h",
					$time, acc_out);
				err_count++;
			end else begin
				want = pending_io_results.pop_front();
				check_field("acc_out", want.acc_out, acc_out);
				check_field("link_out", want.link_out, link_out);
				check_field("skip", want.skip, skip);
				check_field("unsupported", want.unsupported, unsupported);
				check_field("point_valid", want.point_valid, point_valid);
				check_field("point_x", want.point_x, point_x);
				check_field("point_y", want.point_y, point_y);
				check_field("point_shade", want.point_shade, point_shade);
				check_field("irq", want.irq, irq);
			end
		end
	end

	// Watchdog: any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

endmodule
